[rtl/blr_pkg.sv]
// blr_pkg: shared types, constants and the control store of the line rasterizer
// used by blr_seq, blr_datapath and bresenham_line_rasterizer; no dependencies
package blr_pkg;

  // coordinate width inside the datapath and width of the pixel ports
  localparam int COORD_BITS = 6;
  localparam int PIX_W      = 6;
  // signed error term: two spans doubled plus a sign bit
  localparam int ERR_W      = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0]   coord_t;
  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic [1:0]              upc_t;

  // jump conditions of a control word
  typedef enum logic [1:0] {
    COND_ALWAYS = 2'd0,
    COND_IN_ACC = 2'd1,
    COND_LAST   = 2'd2
  } cond_t;

  // one control word per program step
  typedef struct packed {
    logic  in_ready;
    logic  do_setup;
    logic  do_emit;
    logic  stay;
    cond_t cond;
    upc_t  target;
  } ctl_t;

  // datapath status back to the sequencer
  typedef struct packed {
    logic emit_last;
  } sts_t;

  // program steps
  localparam upc_t STEP_LOAD  = 2'd0;
  localparam upc_t STEP_SETUP = 2'd1;
  localparam upc_t STEP_WALK  = 2'd2;

  // control store: load a segment, set up the walk, emit one pixel per cycle while the output is not stalled
  function automatic ctl_t ucode_rom(input upc_t addr);
    ctl_t w;
    w = '{in_ready: 1'b1, do_setup: 1'b0, do_emit: 1'b0, stay: 1'b1,
          cond: COND_IN_ACC, target: STEP_SETUP};
    case (addr)
      STEP_LOAD: begin
        w = '{in_ready: 1'b1, do_setup: 1'b0, do_emit: 1'b0, stay: 1'b1,
              cond: COND_IN_ACC, target: STEP_SETUP};
      end
      STEP_SETUP: begin
        w = '{in_ready: 1'b0, do_setup: 1'b1, do_emit: 1'b0, stay: 1'b0,
              cond: COND_ALWAYS, target: STEP_WALK};
      end
      STEP_WALK: begin
        w = '{in_ready: 1'b0, do_setup: 1'b0, do_emit: 1'b1, stay: 1'b1,
              cond: COND_LAST, target: STEP_LOAD};
      end
      default: begin
        w = '{in_ready: 1'b0, do_setup: 1'b0, do_emit: 1'b0, stay: 1'b0,
              cond: COND_ALWAYS, target: STEP_LOAD};
      end
    endcase
    return w;
  endfunction

endpackage

[rtl/bresenham_line_rasterizer.sv]
// bresenham_line_rasterizer: top level, one segment in, one word per pixel out
// the first pixel word is registered at the walk step, after the load and setup steps
// throughput: one pixel per cycle from the walk step while out_stall is low; the next
//   segment is taken only after the last pixel of a segment (at most 64) is emitted
// reset: synchronous active low; returns the program to the load step and empties
//   the output register; depends on blr_pkg, blr_seq, blr_datapath
module bresenham_line_rasterizer import blr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [PIX_W-1:0] in_x_start,
  input  logic [PIX_W-1:0] in_y_start,
  input  logic [PIX_W-1:0] in_x_end,
  input  logic [PIX_W-1:0] in_y_end,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] out_pix_x,
  output logic [PIX_W-1:0] out_pix_y,
  output logic             out_last_pixel
);

  ctl_t ctl;
  sts_t sts;

  // input is taken only at the load step
  assign in_stall = !ctl.in_ready;

  // sequencer
  blr_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .ctl      (ctl)
  );

  // datapath
  blr_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .in_valid       (in_valid),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_pix_x      (out_pix_x),
    .out_pix_y      (out_pix_y),
    .out_last_pixel (out_last_pixel),
    .sts            (sts)
  );

endmodule

[rtl/blr_seq.sv]
// blr_seq: step counter and control store lookup with conditional jumps
// depends on blr_pkg
module blr_seq import blr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  sts_t sts,
  output ctl_t ctl
);

  upc_t upc_r, upc_nxt;
  logic cond_hit;

  // current control word
  assign ctl = ucode_rom(upc_r);

  // jump condition select and next step
  always_comb begin
    case (ctl.cond)
      COND_ALWAYS: cond_hit = 1'b1;
      COND_IN_ACC: cond_hit = in_valid;
      COND_LAST:   cond_hit = sts.emit_last;
      default:     cond_hit = 1'b0;
    endcase
    if (cond_hit) begin
      upc_nxt = ctl.target;
    end else if (ctl.stay) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = upc_r + 2'd1;
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= STEP_LOAD;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

[rtl/blr_datapath.sv]
// blr_datapath: endpoint latch, walk setup, error term update and pixel output register
// depends on blr_pkg; driven by the control word from blr_seq
module blr_datapath import blr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  ctl_t             ctl,
  input  logic             in_valid,
  input  logic [PIX_W-1:0] in_x_start,
  input  logic [PIX_W-1:0] in_y_start,
  input  logic [PIX_W-1:0] in_x_end,
  input  logic [PIX_W-1:0] in_y_end,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [PIX_W-1:0] out_pix_x,
  output logic [PIX_W-1:0] out_pix_y,
  output logic             out_last_pixel,
  output sts_t             sts
);

  // latched endpoints
  coord_t xs_r, ys_r, xe_r, ye_r;
  // walk state
  coord_t maj_r, mnr_r, maj_end_r;
  err_t   p_r, inc_keep_r, inc_step_r;
  logic   minor_step_neg_r, y_is_major_r;
  // output register
  coord_t cur_x_r, cur_y_r;
  logic   last_r, out_valid_r, out_valid_nxt;

  // setup terms
  coord_t dx, dy, s_maj, s_min, maj0, mnr0, mend0, nend0;
  logic   y_major;
  err_t   keep0, step0, p0;
  // walk terms
  logic   out_free, fire, is_last;
  err_t   p_add;

  // spans, major axis and walk direction from the latched endpoints
  always_comb begin
    dx = (xs_r > xe_r) ? xs_r - xe_r : xe_r - xs_r;
    dy = (ys_r > ye_r) ? ys_r - ye_r : ye_r - ys_r;
    y_major = !(dy < dx);
    if (y_major) begin
      s_maj = dy;
      s_min = dx;
      if (ys_r > ye_r) begin
        maj0 = ye_r; mnr0 = xe_r; mend0 = ys_r; nend0 = xs_r;
      end else begin
        maj0 = ys_r; mnr0 = xs_r; mend0 = ye_r; nend0 = xe_r;
      end
    end else begin
      s_maj = dx;
      s_min = dy;
      if (xs_r > xe_r) begin
        maj0 = xe_r; mnr0 = ye_r; mend0 = xs_r; nend0 = ys_r;
      end else begin
        maj0 = xs_r; mnr0 = ys_r; mend0 = xe_r; nend0 = ye_r;
      end
    end
    keep0 = err_t'({s_min, 1'b0});
    step0 = keep0 - err_t'({s_maj, 1'b0});
    p0    = keep0 - err_t'(s_maj);
  end

  // emit control: output register free when empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = ctl.do_emit && out_free;
  assign is_last  = (maj_r >= maj_end_r);
  assign p_add    = p_r + (p_r[ERR_W-1] ? inc_keep_r : inc_step_r);
  assign sts.emit_last = fire && is_last;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // endpoint latch, setup and walk registers
  always_ff @(posedge clk) begin
    if (ctl.in_ready && in_valid) begin
      xs_r <= in_x_start[COORD_BITS-1:0];
      ys_r <= in_y_start[COORD_BITS-1:0];
      xe_r <= in_x_end[COORD_BITS-1:0];
      ye_r <= in_y_end[COORD_BITS-1:0];
    end
    if (ctl.do_setup) begin
      y_is_major_r     <= y_major;
      maj_r            <= maj0;
      mnr_r            <= mnr0;
      maj_end_r        <= mend0;
      minor_step_neg_r <= (nend0 < mnr0);
      p_r              <= p0;
      inc_keep_r       <= keep0;
      inc_step_r       <= step0;
    end
    if (fire) begin
      cur_x_r <= y_is_major_r ? mnr_r : maj_r;
      cur_y_r <= y_is_major_r ? maj_r : mnr_r;
      last_r  <= is_last;
      if (!is_last) begin
        maj_r <= maj_r + coord_t'(1);
        p_r   <= p_add;
        if (!p_r[ERR_W-1]) begin
          mnr_r <= minor_step_neg_r ? mnr_r - coord_t'(1) : mnr_r + coord_t'(1);
        end
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pix_x      = PIX_W'(cur_x_r);
  assign out_pix_y      = PIX_W'(cur_y_r);
  assign out_last_pixel = last_r;

endmodule

[tb/sv/bresenham_line_rasterizer_tb.sv]
// bresenham_line_rasterizer_tb: self-checking bench for the line rasterizer,
// with an in-bench pixel predictor and a directed table followed by random segments
// depends on blr_pkg and bresenham_line_rasterizer
`timescale 1ns / 100ps

module bresenham_line_rasterizer_tb import blr_pkg::*; ();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_SEGMENTS = 45;
  localparam int NUM_DIRECTED = 17;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t xs;
    pix_t ys;
    pix_t xe;
    pix_t ye;
  } segment_t;

  typedef struct packed {
    pix_t x;
    pix_t y;
    logic last;
  } pixel_t;

  typedef struct packed {
    segment_t seg;
    logic     typed;
    pixel_t   pix;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pix_t in_x_start = '0;
  pix_t in_y_start = '0;
  pix_t in_x_end = '0;
  pix_t in_y_end = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pix_t out_pix_x;
  pix_t out_pix_y;
  logic out_last_pixel;

  pixel_t expected_pixels[$];
  int error_count = 0;
  int segments_sent = 0;
  int pixels_checked = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  // single points carry their one pixel; the rest go through the predictor
  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{6'd0,  6'd0,  6'd0,  6'd0},  1'b1, '{6'd0,  6'd0,  1'b1}},
    '{'{6'd63, 6'd63, 6'd63, 6'd63}, 1'b1, '{6'd63, 6'd63, 1'b1}},
    '{'{6'd42, 6'd21, 6'd42, 6'd21}, 1'b1, '{6'd42, 6'd21, 1'b1}},
    '{'{6'd0,  6'd0,  6'd63, 6'd0},  1'b0, '0},
    '{'{6'd63, 6'd63, 6'd0,  6'd63}, 1'b0, '0},
    '{'{6'd0,  6'd0,  6'd0,  6'd63}, 1'b0, '0},
    '{'{6'd63, 6'd63, 6'd63, 6'd0},  1'b0, '0},
    '{'{6'd0,  6'd0,  6'd63, 6'd63}, 1'b0, '0},
    '{'{6'd63, 6'd63, 6'd0,  6'd0},  1'b0, '0},
    '{'{6'd0,  6'd63, 6'd63, 6'd0},  1'b0, '0},
    '{'{6'd63, 6'd0,  6'd0,  6'd63}, 1'b0, '0},
    '{'{6'd0,  6'd0,  6'd63, 6'd20}, 1'b0, '0},
    '{'{6'd0,  6'd40, 6'd63, 6'd5},  1'b0, '0},
    '{'{6'd10, 6'd0,  6'd30, 6'd63}, 1'b0, '0},
    '{'{6'd50, 6'd63, 6'd5,  6'd0},  1'b0, '0},
    '{'{6'd5,  6'd5,  6'd6,  6'd7},  1'b0, '0},
    '{'{6'd21, 6'd42, 6'd42, 6'd21}, 1'b0, '0}
  };

  bresenham_line_rasterizer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_x_start    (in_x_start),
    .in_y_start    (in_y_start),
    .in_x_end      (in_x_end),
    .in_y_end      (in_y_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pix_x     (out_pix_x),
    .out_pix_y     (out_pix_y),
    .out_last_pixel(out_last_pixel)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // walk the segment along its major axis and queue every pixel it covers
  function automatic void predict_line_pixels(input segment_t s);
    int mask;
    int dx;
    int dy;
    int span_maj;
    int span_min;
    int maj;
    int mnr;
    int maj_end;
    int mnr_end;
    int err;
    int inc_keep;
    int inc_step;
    int n;
    bit y_major;
    bit step_down;
    pixel_t p;
    mask = (1 << COORD_BITS) - 1;
    dx = (s.xs > s.xe) ? int'(s.xs) - int'(s.xe) : int'(s.xe) - int'(s.xs);
    dy = (s.ys > s.ye) ? int'(s.ys) - int'(s.ye) : int'(s.ye) - int'(s.ys);
    y_major = !(dy < dx);
    if (y_major) begin
      span_maj = dy;
      span_min = dx;
      if (s.ys > s.ye) begin
        maj = s.ye; mnr = s.xe; maj_end = s.ys; mnr_end = s.xs;
      end else begin
        maj = s.ys; mnr = s.xs; maj_end = s.ye; mnr_end = s.xe;
      end
    end else begin
      span_maj = dx;
      span_min = dy;
      if (s.xs > s.xe) begin
        maj = s.xe; mnr = s.ye; maj_end = s.xs; mnr_end = s.ys;
      end else begin
        maj = s.xs; mnr = s.ys; maj_end = s.xe; mnr_end = s.ye;
      end
    end
    step_down = (mnr_end < mnr);
    err = 2 * span_min - span_maj;
    inc_keep = 2 * span_min;
    inc_step = 2 * (span_min - span_maj);
    for (n = 0; n < 64; n++) begin
      p.last = (maj >= maj_end);
      p.x = y_major ? pix_t'(mnr) : pix_t'(maj);
      p.y = y_major ? pix_t'(maj) : pix_t'(mnr);
      expected_pixels.push_back(p);
      if (p.last) break;
      maj = (maj + 1) & mask;
      if (err < 0) begin
        err += inc_keep;
      end else begin
        mnr = step_down ? ((mnr - 1) & mask) : ((mnr + 1) & mask);
        err += inc_step;
      end
    end
  endfunction

  // offer one segment word, entered and left at a falling edge
  task automatic send_segment(input segment_t s, input logic typed, input pixel_t pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_x_start <= s.xs;
    in_y_start <= s.ys;
    in_x_end   <= s.xe;
    in_y_end   <= s.ye;
    do @(posedge clk); while (in_stall);
    if (typed) expected_pixels.push_back(pix);
    else predict_line_pixels(s);
    segments_sent++;
    @(negedge clk);
  endtask

  // mostly full-range segments, plus points, axis lines, diagonals and short ones
  function automatic segment_t random_segment();
    segment_t s;
    int d;
    s = {6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom)};
    case ($urandom_range(9))
      0: begin
        s.xe = s.xs;
        s.ye = s.ys;
      end
      1: s.ye = s.ys;
      2: s.xe = s.xs;
      3: begin
        d = $urandom_range(63);
        s.xe = s.xs + pix_t'(d);
        s.ye = $urandom_range(1) ? s.ys + pix_t'(d) : s.ys - pix_t'(d);
        if (s.xe < s.xs) s.xe = s.xs;
        if ((s.ye > s.ys ? s.ye - s.ys : s.ys - s.ye) != s.xe - s.xs) s.ye = s.ys;
      end
      4: begin
        s.xe = s.xs ^ pix_t'($urandom_range(3));
        s.ye = s.ys ^ pix_t'($urandom_range(3));
      end
      default: ;
    endcase
    return s;
  endfunction

  // let the block empty out completely
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver stall: a requested long hold first, otherwise random idling
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_served + 1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // compare each accepted pixel word with the oldest prediction
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $time,
                 out_pix_x, out_pix_y, out_last_pixel);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (out_pix_x !== want.x) begin
          $display("%0t: pix_x expected %0d got %0d", $time, want.x, out_pix_x);
          error_count++;
        end
        if (out_pix_y !== want.y) begin
          $display("%0t: pix_y expected %0d got %0d", $time, want.y, out_pix_y);
          error_count++;
        end
        if (out_last_pixel !== want.last) begin
          $display("%0t: last_pixel expected %0b got %0b", $time, want.last,
                   out_last_pixel);
          error_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout with %0d pixels outstanding", $time, expected_pixels.size());
    $display("bresenham_line_rasterizer_tb failed");
    $finish;
  end

  initial begin
    int i;
    // hold reset, then release it at a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (i = 0; i < NUM_DIRECTED; i++) begin
      send_segment(directed_rows[i].seg, directed_rows[i].typed, directed_rows[i].pix);
    end
    wait_for_drain();

    // random, slow sender against a busy receiver
    send_idle_pct = 27;
    recv_idle_pct = 82;
    for (i = 0; i < PHASE_SEGMENTS; i++) send_segment(random_segment(), 1'b0, '0);
    wait_for_drain();

    // random, the other way round
    send_idle_pct = 82;
    recv_idle_pct = 27;
    for (i = 0; i < PHASE_SEGMENTS; i++) send_segment(random_segment(), 1'b0, '0);
    wait_for_drain();

    // full rate, opened by a long receiver hold so the input backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = hold_requests + 1;
    for (i = 0; i < PHASE_SEGMENTS; i++) send_segment(random_segment(), 1'b0, '0);
    wait_for_drain();

    // catch any stray pixel words
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d segments (points, axis lines, diagonals, reversed, random)",
             segments_sent);
    $display("checked %0d pixel words, %0d mismatches", pixels_checked, error_count);
    if (error_count == 0) begin
      $display("bresenham_line_rasterizer_tb passed");
    end else begin
      $display("bresenham_line_rasterizer_tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/blr_pkg.sv
rtl/blr_seq.sv
rtl/blr_datapath.sv
rtl/bresenham_line_rasterizer.sv
tb/sv/bresenham_line_rasterizer_tb.sv
